[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold outside reset
`define CHK_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/tsci_pkg.sv]
// ----------------------------------------------------------------------------
// tsci_pkg
// Shared types and constants of the text screen control interpreter.
// ----------------------------------------------------------------------------
package tsci_pkg;

  // character codes
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_U     = 8'h75;

  // escape progress as reported on the result
  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_CARET = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  // a cell: bit 8 blank flag, bits 7..0 character
  localparam logic [8:0] BLANK_CELL = 9'h100;

  localparam int QDEPTH = 2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUT,
    OP_COL0,
    OP_CLEAR,
    OP_DOWN,
    OP_UP,
    OP_LEFT,
    OP_RIGHT,
    OP_DELETE,
    OP_HOME,
    OP_SETCUR,
    OP_READ
  } op_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] code;        // character for OP_PUT
    logic [3:0] arg_row;     // read row or first cursor digit
    logic [3:0] arg_col;     // read column or second cursor digit
    logic       insert_on;   // mode after this word
    logic [1:0] esc;         // escape progress after this word
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/tsci_in_if.sv]
// ----------------------------------------------------------------------------
// tsci_in_if
// Input channel: one word per action (feed a byte or read a cell).
// ----------------------------------------------------------------------------
interface tsci_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_in;
  logic [3:0] read_row;
  logic [3:0] read_col;

  modport source (output valid, action, byte_in, read_row, read_col, input ready);
  modport sink   (input valid, action, byte_in, read_row, read_col, output ready);
endinterface

[hdl/tsci_out_if.sv]
// ----------------------------------------------------------------------------
// tsci_out_if
// Result channel: one word per accepted input word.
// ----------------------------------------------------------------------------
interface tsci_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_code;
  logic       cell_blank;
  logic [3:0] cursor_row_out;
  logic [3:0] cursor_col_out;
  logic       insert_on;
  logic [1:0] escape_pending;

  modport source (output valid, cell_code, cell_blank, cursor_row_out, cursor_col_out,
                  insert_on, escape_pending, input ready);
  modport sink   (input valid, cell_code, cell_blank, cursor_row_out, cursor_col_out,
                  insert_on, escape_pending, output ready);
endinterface

[hdl/tsci_front.sv]
// ----------------------------------------------------------------------------
// tsci_front
// Accepts input words, tracks escape progress and mode, emits commands.
// ----------------------------------------------------------------------------
module tsci_front (
  input  logic             clk,
  input  logic             rst,
  tsci_in_if.sink          item,
  input  tsci_pkg::q_stat_t q_stat,
  output logic             push,
  output tsci_pkg::cmd_t   cmd
);

  logic [1:0] esc, esc_next;
  logic       insert_mode, insert_mode_next;
  logic [3:0] pending_row, pending_row_next;
  logic       is_digit;
  logic [7:0] digit_val;

  assign item.ready = !q_stat.full;
  assign push       = item.valid && item.ready;

  assign is_digit  = (item.byte_in >= tsci_pkg::CH_ZERO) && (item.byte_in <= tsci_pkg::CH_NINE);
  assign digit_val = item.byte_in - tsci_pkg::CH_ZERO;

  always_comb begin
    esc_next         = esc;
    insert_mode_next = insert_mode;
    pending_row_next = pending_row;
    cmd.op           = tsci_pkg::OP_NONE;
    cmd.code         = item.byte_in;
    cmd.arg_row      = item.read_row;
    cmd.arg_col      = item.read_col;
    if (item.action) begin
      cmd.op = tsci_pkg::OP_READ;
    end else begin
      unique case (esc)
        tsci_pkg::ESC_DIGIT: begin
          esc_next    = tsci_pkg::ESC_IDLE;
          cmd.arg_row = pending_row;
          cmd.arg_col = digit_val[3:0];
          if (is_digit) cmd.op = tsci_pkg::OP_SETCUR;
        end
        tsci_pkg::ESC_CARET: begin
          esc_next = tsci_pkg::ESC_IDLE;
          priority case (item.byte_in)
            tsci_pkg::CH_B:     cmd.op = tsci_pkg::OP_COL0;
            tsci_pkg::CH_C:     cmd.op = tsci_pkg::OP_CLEAR;
            tsci_pkg::CH_D:     cmd.op = tsci_pkg::OP_DOWN;
            tsci_pkg::CH_U:     cmd.op = tsci_pkg::OP_UP;
            tsci_pkg::CH_L:     cmd.op = tsci_pkg::OP_LEFT;
            tsci_pkg::CH_R:     cmd.op = tsci_pkg::OP_RIGHT;
            tsci_pkg::CH_E:     cmd.op = tsci_pkg::OP_DELETE;
            tsci_pkg::CH_H:     cmd.op = tsci_pkg::OP_HOME;
            tsci_pkg::CH_I:     insert_mode_next = 1'b1;
            tsci_pkg::CH_O:     insert_mode_next = 1'b0;
            tsci_pkg::CH_CARET: cmd.op = tsci_pkg::OP_PUT;
            default: begin
              if (is_digit) begin
                pending_row_next = digit_val[3:0];
                esc_next         = tsci_pkg::ESC_DIGIT;
              end
            end
          endcase
        end
        default: begin
          // idle: caret opens an escape, newline dropped, rest is printed
          if (item.byte_in == tsci_pkg::CH_CARET) begin
            esc_next = tsci_pkg::ESC_CARET;
          end else if (item.byte_in != tsci_pkg::CH_NL) begin
            cmd.op = tsci_pkg::OP_PUT;
          end
        end
      endcase
    end
    cmd.insert_on = insert_mode_next;
    cmd.esc       = esc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc         <= tsci_pkg::ESC_IDLE;
      insert_mode <= 1'b0;
      pending_row <= '0;
    end else if (push) begin
      esc         <= esc_next;
      insert_mode <= insert_mode_next;
      pending_row <= pending_row_next;
    end
  end

endmodule

[hdl/tsci_queue.sv]
// ----------------------------------------------------------------------------
// tsci_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module tsci_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsci_pkg::cmd_t    din,
  input  logic              pop,
  output tsci_pkg::cmd_t    dout,
  output tsci_pkg::q_stat_t stat
);

  tsci_pkg::cmd_t ents [tsci_pkg::QDEPTH];
  logic       wp, rp;
  logic [1:0] cnt;

  assign dout       = ents[rp];
  assign stat.full  = (cnt == 2'(tsci_pkg::QDEPTH));
  assign stat.empty = (cnt == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ents[wp] <= din;
  end

endmodule

[hdl/tsci_back.sv]
// ----------------------------------------------------------------------------
// tsci_back
// Executes commands on the row-wide screen memory and drives results.
// ----------------------------------------------------------------------------
module tsci_back #(
  parameter int ROWS = 10,
  parameter int COLS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  tsci_pkg::cmd_t    cmd,
  input  tsci_pkg::q_stat_t q_stat,
  output logic              pop,
  tsci_out_if.source        result
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  typedef enum logic {S_FETCH, S_EXEC} state_t;
  typedef logic [COLS-1:0][8:0] row_t;

  state_t         state;
  tsci_pkg::cmd_t op_q;
  row_t           mem [ROWS];
  logic [ROWS-1:0] row_valid;
  row_t           row_q;
  logic           row_ok;
  logic [RW-1:0]  cur_row, row_n, rd_idx;
  logic [CW-1:0]  cur_col, col_n;

  row_t           row_old, row_new, shr, shl;
  logic           wr_en, clr;
  logic [RW+3:0]  cmd_row_ext, arg_row_ext, out_row_ext;
  logic [CW+3:0]  arg_col_ext, out_col_ext;
  logic           rd_in_range;
  logic [8:0]     rd_cell;

  assign pop = (state == S_FETCH) && !q_stat.empty && (!result.valid || result.ready);

  // read address: target row of a read, else the cursor row
  assign cmd_row_ext = {{RW{1'b0}}, cmd.arg_row};
  assign rd_idx = (cmd.op == tsci_pkg::OP_READ) ? cmd_row_ext[RW-1:0] : cur_row;

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      row_q  <= mem[rd_idx];
      row_ok <= row_valid[rd_idx];
    end
    if (wr_en) mem[cur_row] <= row_new;
  end

  assign arg_row_ext = {{RW{1'b0}}, op_q.arg_row};
  assign arg_col_ext = {{CW{1'b0}}, op_q.arg_col};
  assign row_old = row_ok ? row_q : {COLS{tsci_pkg::BLANK_CELL}};
  assign shr     = {row_old[COLS-2:0], tsci_pkg::BLANK_CELL};
  assign shl     = {tsci_pkg::BLANK_CELL, row_old[COLS-1:1]};
  assign rd_in_range = (int'(op_q.arg_row) < ROWS) && (int'(op_q.arg_col) < COLS);
  assign rd_cell = row_old[arg_col_ext[CW-1:0]];

  always_comb begin
    row_n   = cur_row;
    col_n   = cur_col;
    row_new = row_old;
    wr_en   = 1'b0;
    clr     = 1'b0;
    if (state == S_EXEC) begin
      unique case (op_q.op)
        tsci_pkg::OP_PUT: begin
          wr_en = 1'b1;
          for (int c = 0; c < COLS; c++) begin
            if (CW'(c) == cur_col) row_new[c] = {1'b0, op_q.code};
            else if (op_q.insert_on && CW'(c) > cur_col) row_new[c] = shr[c];
          end
          if (int'(cur_col) < COLS - 1) col_n = cur_col + CW'(1);
        end
        tsci_pkg::OP_DELETE: begin
          wr_en = 1'b1;
          for (int c = 0; c < COLS; c++) begin
            if (CW'(c) >= cur_col) row_new[c] = shl[c];
          end
        end
        tsci_pkg::OP_COL0:  col_n = '0;
        tsci_pkg::OP_CLEAR: clr = 1'b1;
        tsci_pkg::OP_DOWN:  if (int'(cur_row) < ROWS - 1) row_n = cur_row + RW'(1);
        tsci_pkg::OP_UP:    if (cur_row != '0) row_n = cur_row - RW'(1);
        tsci_pkg::OP_LEFT:  if (cur_col != '0) col_n = cur_col - CW'(1);
        tsci_pkg::OP_RIGHT: if (int'(cur_col) < COLS - 1) col_n = cur_col + CW'(1);
        tsci_pkg::OP_HOME: begin
          row_n = '0;
          col_n = '0;
        end
        tsci_pkg::OP_SETCUR: begin
          // digits beyond the screen saturate at the last row / column
          row_n = (int'(op_q.arg_row) < ROWS) ? arg_row_ext[RW-1:0] : RW'(ROWS - 1);
          col_n = (int'(op_q.arg_col) < COLS) ? arg_col_ext[CW-1:0] : CW'(COLS - 1);
        end
        default: ;
      endcase
    end
  end

  assign out_row_ext = {4'b0, row_n};
  assign out_col_ext = {4'b0, col_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FETCH;
      result.valid <= 1'b0;
      cur_row      <= '0;
      cur_col      <= '0;
      row_valid    <= '0;
    end else begin
      unique case (state)
        S_FETCH: begin
          if (result.valid && result.ready) result.valid <= 1'b0;
          if (pop) begin
            op_q  <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state   <= S_FETCH;
          cur_row <= row_n;
          cur_col <= col_n;
          if (clr)   row_valid <= '0;
          if (wr_en) row_valid[cur_row] <= 1'b1;
          result.valid          <= 1'b1;
          result.cursor_row_out <= out_row_ext[3:0];
          result.cursor_col_out <= out_col_ext[3:0];
          result.insert_on      <= op_q.insert_on;
          result.escape_pending <= op_q.esc;
          if (op_q.op == tsci_pkg::OP_READ) begin
            result.cell_blank <= !rd_in_range || rd_cell[8];
            result.cell_code  <= (!rd_in_range || rd_cell[8]) ? 8'd0 : rd_cell[7:0];
          end else begin
            result.cell_blank <= 1'b0;
            result.cell_code  <= 8'd0;
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

endmodule

[hdl/text_screen_control_interpreter_top.sv]
// ----------------------------------------------------------------------------
// text_screen_control_interpreter_top
// Character screen driven by a byte stream with caret escapes.
//
// Channels: item (sink) carries one action word: action 0 feeds byte_in to
// the interpreter, action 1 reads the cell at read_row/read_col. result
// (source) returns exactly one word per accepted item, in order: the read
// cell (zero for feeds), cursor position, insert mode and escape progress.
// Both use valid/ready; a word moves when both are high on a clock edge.
// An accepted item passes the queue, then the back end's fetch and execute
// states, a read-modify-write of one row word in the screen memory (read,
// then update and write); the back end takes no new command before it is
// done. A 2-entry queue lets the front keep accepting while the back end
// works or waits; when result is stalled the back end holds its output
// register and the queue fills, after which item.ready drops.
// Reset (rst, synchronous): cursor home, overwrite mode, escape idle,
// screen blank. Blanking uses per-row valid bits cleared at once, so there
// is no clearing pass; ^c blanks the screen the same way.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_screen_control_interpreter_top #(
  parameter int ROWS = 10,
  parameter int COLS = 10
) (
  input logic        clk,
  input logic        rst,
  tsci_in_if.sink    item,
  tsci_out_if.source result
);

  tsci_pkg::cmd_t    cmd_in, cmd_out;
  tsci_pkg::q_stat_t q_stat;
  logic              push, pop;

  // front: handshake, escape tracking, classification
  tsci_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (cmd_in)
  );

  tsci_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .pop  (pop),
    .dout (cmd_out),
    .stat (q_stat)
  );

  // back: cursor, screen memory, result register
  tsci_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_out),
    .q_stat (q_stat),
    .pop    (pop),
    .result (result)
  );

  `CHK_NEVER(a_q_full_empty, q_stat.full && q_stat.empty, "queue full and empty")
  `CHK_IMPLY(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
  `CHK_NEVER(a_push_full, push && q_stat.full, "push into full queue")
  `CHK_IMPLY(a_cursor_range, result.valid,
             (ROWS > 16) || (int'(result.cursor_row_out) < ROWS), "cursor row off screen")

endmodule
